>>> sv/stsc_pkg.sv
`default_nettype none
package stsc_pkg;

  localparam int LINE_BITS_DEF   = 16;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int POS_W           = 16;
  localparam int Q_DEPTH         = 4;
  localparam int Q_AW            = $clog2(Q_DEPTH);

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_SLASH = 4'd1,
    MODE_LCOM  = 4'd2,
    MODE_BCOM  = 4'd3,
    MODE_BSTAR = 4'd4,
    MODE_IDENT = 4'd5,
    MODE_NUM   = 4'd6,
    MODE_STR   = 4'd7,
    MODE_ERR   = 4'd8
  } mode_t;

  localparam logic [4:0] K_LCOM  = 5'd0;
  localparam logic [4:0] K_BCOM  = 5'd1;
  localparam logic [4:0] K_IDENT = 5'd2;
  localparam logic [4:0] K_STR   = 5'd3;
  localparam logic [4:0] K_NUM   = 5'd4;
  localparam logic [4:0] K_PLUS  = 5'd5;
  localparam logic [4:0] K_MINUS = 5'd6;
  localparam logic [4:0] K_STAR  = 5'd7;
  localparam logic [4:0] K_DIV   = 5'd8;
  localparam logic [4:0] K_EQ    = 5'd9;
  localparam logic [4:0] K_LPAR  = 5'd10;
  localparam logic [4:0] K_RPAR  = 5'd11;
  localparam logic [4:0] K_LBRK  = 5'd12;
  localparam logic [4:0] K_RBRK  = 5'd13;
  localparam logic [4:0] K_LBRC  = 5'd14;
  localparam logic [4:0] K_RBRC  = 5'd15;
  localparam logic [4:0] K_SEMI  = 5'd16;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CHAR   = 2'd1;
  localparam logic [1:0] ERR_BCOM   = 2'd2;
  localparam logic [1:0] ERR_STRING = 2'd3;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [4:0]       kind;
    logic [7:0]       text_byte;
    logic             text_valid;
    logic             token_last;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
    logic [1:0]       error;
  } out_item_t;

  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } pair_t;

endpackage
`default_nettype wire

>>> sv/stsc_front.sv
`default_nettype none
module stsc_front #(
  parameter int LINE_BITS   = stsc_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stsc_pkg::COLUMN_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               full,
  input  wire stsc_pkg::in_item_t in_data,
  output logic                    push,
  output stsc_pkg::pair_t         push_data
);
  import stsc_pkg::*;

  typedef struct packed {
    mode_t     mode;
    logic      set_start;
    logic      emit;
    out_item_t res;
  } idle_t;

  mode_t                  mode, mode_next;
  logic [LINE_BITS-1:0]   line_count;
  logic [COLUMN_BITS-1:0] column_count;
  logic [LINE_BITS-1:0]   start_line, start_next;
  logic                   accept;
  logic [POS_W-1:0]       cur_line, tok_line, cur_col;
  logic [7:0]             c;
  idle_t                  idl;
  out_item_t              r0, r1;
  logic [1:0]             n;

  function automatic logic is_word(input logic [7:0] x);
    return (x inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || x == CH_USCORE;
  endfunction

  function automatic logic is_digit(input logic [7:0] x);
    return x inside {[8'h30:8'h39]};
  endfunction

  function automatic out_item_t mk(input logic [4:0] k, input logic [7:0] b, input logic v,
                                   input logic l, input logic [POS_W-1:0] ln,
                                   input logic [POS_W-1:0] col, input logic [1:0] e);
    out_item_t r;
    r.kind       = k;
    r.text_byte  = b;
    r.text_valid = v;
    r.token_last = l;
    r.line       = ln;
    r.column     = col;
    r.error      = e;
    return r;
  endfunction

  function automatic idle_t scan_idle(input logic [7:0] x, input logic [POS_W-1:0] ln,
                                      input logic [POS_W-1:0] col);
    idle_t r;
    r.mode      = MODE_IDLE;
    r.set_start = 1'b0;
    r.emit      = 1'b0;
    r.res       = '0;
    if (x == 8'h20 || (x inside {[8'h09:8'h0D]})) begin
      r.mode = MODE_IDLE;
    end else if (x == CH_SLASH) begin
      r.mode      = MODE_SLASH;
      r.set_start = 1'b1;
    end else if (is_word(x)) begin
      r.mode      = MODE_IDENT;
      r.set_start = 1'b1;
      r.emit      = 1'b1;
      r.res       = mk(K_IDENT, x, 1'b1, 1'b0, ln, col, ERR_NONE);
    end else if (is_digit(x)) begin
      r.mode      = MODE_NUM;
      r.set_start = 1'b1;
      r.emit      = 1'b1;
      r.res       = mk(K_NUM, x, 1'b1, 1'b0, ln, col, ERR_NONE);
    end else if (x == CH_QUOTE) begin
      r.mode      = MODE_STR;
      r.set_start = 1'b1;
    end else begin
      r.emit = 1'b1;
      case (x)
        CH_PLUS:  r.res = mk(K_PLUS,  8'h00, 1'b0, 1'b1, ln, col, ERR_NONE);
        8'h2D:    r.res = mk(K_MINUS, 8'h00, 1'b0, 1'b1, ln, col, ERR_NONE);
        CH_STAR:  r.res = mk(K_STAR,  8'h00, 1'b0, 1'b1, ln, col, ERR_NONE);
        8'h3D:    r.res = mk(K_EQ,    8'h00, 1'b0, 1'b1, ln, col, ERR_NONE);
        8'h28:    r.res = mk(K_LPAR,  8'h00, 1'b0, 1'b1, ln, col, ERR_NONE);
        8'h29:    r.res = mk(K_RPAR,  8'h00, 1'b0, 1'b1, ln, col, ERR_NONE);
        8'h5B:    r.res = mk(K_LBRK,  8'h00, 1'b0, 1'b1, ln, col, ERR_NONE);
        8'h5D:    r.res = mk(K_RBRK,  8'h00, 1'b0, 1'b1, ln, col, ERR_NONE);
        8'h7B:    r.res = mk(K_LBRC,  8'h00, 1'b0, 1'b1, ln, col, ERR_NONE);
        8'h7D:    r.res = mk(K_RBRC,  8'h00, 1'b0, 1'b1, ln, col, ERR_NONE);
        CH_SEMI:  r.res = mk(K_SEMI,  8'h00, 1'b0, 1'b1, ln, col, ERR_NONE);
        default: begin
          r.res  = mk(K_LCOM, 8'h00, 1'b0, 1'b0, ln, col, ERR_CHAR);
          r.mode = MODE_ERR;
        end
      endcase
    end
    return r;
  endfunction

  assign accept   = in_valid && !full;
  assign c        = in_data.ch;
  assign cur_line = POS_W'(line_count);
  assign tok_line = POS_W'(start_line);
  assign cur_col  = POS_W'(column_count);
  assign idl      = scan_idle(c, cur_line, cur_col);

  always_comb begin
    mode_next  = mode;
    start_next = start_line;
    n          = 2'd0;
    r0         = '0;
    r1         = '0;
    if (in_data.is_end) begin
      mode_next = MODE_IDLE;
      n         = 2'd1;
      case (mode)
        MODE_SLASH: r0 = mk(K_DIV,   8'h00, 1'b0, 1'b1, tok_line, cur_col, ERR_NONE);
        MODE_LCOM:  r0 = mk(K_LCOM,  8'h00, 1'b0, 1'b1, tok_line, cur_col, ERR_NONE);
        MODE_IDENT: r0 = mk(K_IDENT, 8'h00, 1'b0, 1'b1, tok_line, cur_col, ERR_NONE);
        MODE_NUM:   r0 = mk(K_NUM,   8'h00, 1'b0, 1'b1, tok_line, cur_col, ERR_NONE);
        MODE_BCOM, MODE_BSTAR:
          r0 = mk(K_BCOM, 8'h00, 1'b0, 1'b0, tok_line, cur_col, ERR_BCOM);
        MODE_STR:   r0 = mk(K_STR,   8'h00, 1'b0, 1'b0, tok_line, cur_col, ERR_STRING);
        default:    n  = 2'd0;
      endcase
    end else begin
      case (mode)
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            mode_next = MODE_LCOM;
          end else if (c == CH_STAR) begin
            mode_next = MODE_BCOM;
          end else begin
            r0        = mk(K_DIV, 8'h00, 1'b0, 1'b1, tok_line, cur_col, ERR_NONE);
            n         = 2'd1;
            mode_next = idl.mode;
            if (idl.set_start) start_next = line_count;
            if (idl.emit) begin
              r1 = idl.res;
              n  = 2'd2;
            end
          end
        end
        MODE_LCOM: begin
          n = 2'd1;
          if (c == CH_LF) begin
            r0        = mk(K_LCOM, 8'h00, 1'b0, 1'b1, tok_line, cur_col, ERR_NONE);
            mode_next = MODE_IDLE;
          end else begin
            r0 = mk(K_LCOM, c, 1'b1, 1'b0, tok_line, cur_col, ERR_NONE);
          end
        end
        MODE_BCOM: begin
          if (c == CH_STAR) begin
            mode_next = MODE_BSTAR;
          end else begin
            r0 = mk(K_BCOM, c, 1'b1, 1'b0, tok_line, cur_col, ERR_NONE);
            n  = 2'd1;
          end
        end
        MODE_BSTAR: begin
          n = 2'd1;
          if (c == CH_SLASH) begin
            r0        = mk(K_BCOM, 8'h00, 1'b0, 1'b1, tok_line, cur_col, ERR_NONE);
            mode_next = MODE_IDLE;
          end else begin
            r0 = mk(K_BCOM, CH_STAR, 1'b1, 1'b0, tok_line, cur_col, ERR_NONE);
            if (c != CH_STAR) begin
              r1        = mk(K_BCOM, c, 1'b1, 1'b0, tok_line, cur_col, ERR_NONE);
              n         = 2'd2;
              mode_next = MODE_BCOM;
            end
          end
        end
        MODE_IDENT, MODE_NUM: begin
          n = 2'd1;
          if ((mode == MODE_IDENT && (is_word(c) || is_digit(c))) ||
              (mode == MODE_NUM && (is_digit(c) || c == CH_DOT))) begin
            r0 = mk((mode == MODE_IDENT) ? K_IDENT : K_NUM, c, 1'b1, 1'b0,
                    tok_line, cur_col, ERR_NONE);
          end else begin
            r0        = mk((mode == MODE_IDENT) ? K_IDENT : K_NUM, 8'h00, 1'b0, 1'b1,
                           tok_line, cur_col, ERR_NONE);
            mode_next = idl.mode;
            if (idl.set_start) start_next = line_count;
            if (idl.emit) begin
              r1 = idl.res;
              n  = 2'd2;
            end
          end
        end
        MODE_STR: begin
          n = 2'd1;
          if (c == CH_QUOTE) begin
            r0        = mk(K_STR, 8'h00, 1'b0, 1'b1, tok_line, cur_col, ERR_NONE);
            mode_next = MODE_IDLE;
          end else begin
            r0 = mk(K_STR, c, 1'b1, 1'b0, tok_line, cur_col, ERR_NONE);
          end
        end
        MODE_ERR: mode_next = MODE_ERR;
        default: begin
          mode_next = idl.mode;
          if (idl.set_start) start_next = line_count;
          if (idl.emit) begin
            r0 = idl.res;
            n  = 2'd1;
          end
        end
      endcase
    end
  end

  assign push             = accept && (n != 2'd0);
  assign push_data.two    = (n == 2'd2);
  assign push_data.first  = r0;
  assign push_data.second = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      line_count   <= LINE_BITS'(1);
      column_count <= COLUMN_BITS'(1);
      start_line   <= LINE_BITS'(1);
    end else if (accept) begin
      if (in_data.is_end) begin
        mode         <= MODE_IDLE;
        line_count   <= LINE_BITS'(1);
        column_count <= COLUMN_BITS'(1);
        start_line   <= LINE_BITS'(1);
      end else begin
        mode       <= mode_next;
        start_line <= start_next;
        if (mode_next != MODE_ERR) begin
          if (c == CH_LF) begin
            if (line_count != '1) line_count <= line_count + LINE_BITS'(1);
            column_count <= COLUMN_BITS'(1);
          end else if (column_count != '1) begin
            column_count <= column_count + COLUMN_BITS'(1);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/stsc_queue.sv
`default_nettype none
module stsc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire stsc_pkg::pair_t push_data,
  input  wire logic            pop,
  output logic                 full,
  output logic                 q_valid,
  output stsc_pkg::pair_t      q_data
);
  import stsc_pkg::*;

  pair_t           mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push, do_pop;

  assign full    = (count == (Q_AW+1)'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + Q_AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + Q_AW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (Q_AW+1)'(1);
        2'b01:   count <= count - (Q_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/stsc_back.sv
`default_nettype none
module stsc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire stsc_pkg::pair_t q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output stsc_pkg::out_item_t  out_data
);
  import stsc_pkg::*;

  pair_t hold;
  logic  hold_valid;
  logic  sel;
  logic  take;
  logic  done;

  assign out_valid = hold_valid;
  assign out_data  = sel ? hold.second : hold.first;
  assign take      = hold_valid && !out_stall;
  assign done      = take && (sel || !hold.two);
  assign pop       = q_valid && (!hold_valid || done);

  always_ff @(posedge clk) begin
    if (pop) hold <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      sel        <= 1'b0;
    end else if (pop) begin
      hold_valid <= 1'b1;
      sel        <= 1'b0;
    end else if (done) begin
      hold_valid <= 1'b0;
      sel        <= 1'b0;
    end else if (take) begin
      sel <= 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> sv/source_token_scanner.sv
// Source token scanner.
// Input channel: in_valid / in_stall / in_data carries one source byte (ch) or an
// end-of-input marker (is_end). Output channel: out_valid / out_stall / out_data
// carries token items: text bytes, token ends, operators and error reports.
// An item is taken at a rising edge with valid high and stall low.
// Throughput: one input item per cycle while in_stall is low. in_stall only rises
// when the four-entry result queue is full.
// An input item yields zero, one or two output items; the output side sends one
// per cycle while out_stall is low, so a stream of two-result items is paced
// by the output register. A result is written into the queue at the edge that
// accepts its input item, then loaded into the output hold register, from which
// it is offered on out_valid.
// Reset (rst, synchronous, active high) empties the queue and output register and
// returns mode to idle, line and column to one.
// While out_stall is high the offered item holds; the queue keeps filling until
// full, after which in_stall holds the input side.
// An end-of-input item flushes any open token and resets mode, line and column.
`default_nettype none
module source_token_scanner #(
  parameter int LINE_BITS   = stsc_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stsc_pkg::COLUMN_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire stsc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output stsc_pkg::out_item_t      out_data
);
  import stsc_pkg::*;

  logic  push, pop, full, q_valid;
  pair_t push_data, q_data;

  assign in_stall = full;

  stsc_front #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .full      (full),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  stsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  stsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> sv/stsc_checker.sv
`default_nettype none
module stsc_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire stsc_pkg::out_item_t out_data
);
  import stsc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output item changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  a_text_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.text_valid |-> !out_data.token_last && out_data.error == ERR_NONE)
    else $error("text item marked as token end or error");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error != ERR_NONE |-> !out_data.text_valid && !out_data.token_last
      && out_data.text_byte == 8'h00)
    else $error("malformed error item");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.line != '0 && out_data.column != '0)
    else $error("zero line or column");

endmodule

bind source_token_scanner stsc_checker u_stsc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

>>> tb/token_stream_checker.sv
module token_stream_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire stsc_pkg::in_item_t  in_data,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire stsc_pkg::out_item_t out_data,
  output int                      mismatches,
  output int                      tokens_owed
);
  import stsc_pkg::*;

  localparam logic [15:0] POS_MAX = 16'hFFFF;
  localparam logic [4:0]  K_NONE  = 5'd31;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  mode_t       scan_mode;
  logic [15:0] line_no;
  logic [15:0] col_no;
  logic [15:0] tok_line;
  out_item_t   tokens_due[$];

  function automatic logic is_letter(logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic [4:0] op_kind(logic [7:0] c);
    case (c)
      CH_PLUS:  return K_PLUS;
      CH_MINUS: return K_MINUS;
      CH_STAR:  return K_STAR;
      CH_EQ:    return K_EQ;
      CH_LPAR:  return K_LPAR;
      CH_RPAR:  return K_RPAR;
      CH_LBRK:  return K_LBRK;
      CH_RBRK:  return K_RBRK;
      CH_LBRC:  return K_LBRC;
      CH_RBRC:  return K_RBRC;
      CH_SEMI:  return K_SEMI;
      default:  return K_NONE;
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic emit(input logic [4:0] k, input logic [7:0] b, input logic v,
                      input logic last, input logic [15:0] ln, input logic [1:0] err);
    out_item_t r;
    r.kind       = k;
    r.text_byte  = b;
    r.text_valid = v;
    r.token_last = last;
    r.line       = ln;
    r.column     = col_no;
    r.error      = err;
    tokens_due = {tokens_due, r};
    tokens_owed++;
  endtask

  task automatic restart();
    scan_mode = MODE_IDLE;
    line_no   = 1;
    col_no    = 1;
    tok_line  = 1;
  endtask

  task automatic open_token(input logic [7:0] c);
    logic [4:0] k;
    k = op_kind(c);
    scan_mode = MODE_IDLE;
    if (is_blank(c)) begin
    end else if (c == CH_SLASH) begin
      scan_mode = MODE_SLASH;
      tok_line  = line_no;
    end else if (is_letter(c) || c == CH_USCORE) begin
      scan_mode = MODE_IDENT;
      tok_line  = line_no;
      emit(K_IDENT, c, 1'b1, 1'b0, tok_line, ERR_NONE);
    end else if (is_digit(c)) begin
      scan_mode = MODE_NUM;
      tok_line  = line_no;
      emit(K_NUM, c, 1'b1, 1'b0, tok_line, ERR_NONE);
    end else if (c == CH_QUOTE) begin
      scan_mode = MODE_STR;
      tok_line  = line_no;
    end else if (k != K_NONE) begin
      emit(k, 8'h00, 1'b0, 1'b1, line_no, ERR_NONE);
    end else begin
      emit(K_LCOM, 8'h00, 1'b0, 1'b0, line_no, ERR_CHAR);
      scan_mode = MODE_ERR;
    end
  endtask

  task automatic close_stream();
    case (scan_mode)
      MODE_SLASH: emit(K_DIV, 8'h00, 1'b0, 1'b1, tok_line, ERR_NONE);
      MODE_LCOM:  emit(K_LCOM, 8'h00, 1'b0, 1'b1, tok_line, ERR_NONE);
      MODE_IDENT: emit(K_IDENT, 8'h00, 1'b0, 1'b1, tok_line, ERR_NONE);
      MODE_NUM:   emit(K_NUM, 8'h00, 1'b0, 1'b1, tok_line, ERR_NONE);
      MODE_BCOM, MODE_BSTAR: emit(K_BCOM, 8'h00, 1'b0, 1'b0, tok_line, ERR_BCOM);
      MODE_STR:   emit(K_STR, 8'h00, 1'b0, 1'b0, tok_line, ERR_STRING);
      default: ;
    endcase
    restart();
  endtask

  task automatic scan_byte(input in_item_t it);
    logic [7:0] c;
    c = it.ch;
    if (it.is_end) begin
      close_stream();
    end else if (scan_mode != MODE_ERR) begin
      case (scan_mode)
        MODE_SLASH: begin
          if (c == CH_SLASH) scan_mode = MODE_LCOM;
          else if (c == CH_STAR) scan_mode = MODE_BCOM;
          else begin
            emit(K_DIV, 8'h00, 1'b0, 1'b1, tok_line, ERR_NONE);
            open_token(c);
          end
        end
        MODE_LCOM: begin
          if (c == CH_LF) begin
            emit(K_LCOM, 8'h00, 1'b0, 1'b1, tok_line, ERR_NONE);
            scan_mode = MODE_IDLE;
          end else emit(K_LCOM, c, 1'b1, 1'b0, tok_line, ERR_NONE);
        end
        MODE_BCOM: begin
          if (c == CH_STAR) scan_mode = MODE_BSTAR;
          else emit(K_BCOM, c, 1'b1, 1'b0, tok_line, ERR_NONE);
        end
        MODE_BSTAR: begin
          if (c == CH_SLASH) begin
            emit(K_BCOM, 8'h00, 1'b0, 1'b1, tok_line, ERR_NONE);
            scan_mode = MODE_IDLE;
          end else begin
            emit(K_BCOM, CH_STAR, 1'b1, 1'b0, tok_line, ERR_NONE);
            if (c != CH_STAR) begin
              emit(K_BCOM, c, 1'b1, 1'b0, tok_line, ERR_NONE);
              scan_mode = MODE_BCOM;
            end
          end
        end
        MODE_IDENT: begin
          if (is_letter(c) || is_digit(c) || c == CH_USCORE)
            emit(K_IDENT, c, 1'b1, 1'b0, tok_line, ERR_NONE);
          else begin
            emit(K_IDENT, 8'h00, 1'b0, 1'b1, tok_line, ERR_NONE);
            open_token(c);
          end
        end
        MODE_NUM: begin
          if (is_digit(c) || c == CH_DOT) emit(K_NUM, c, 1'b1, 1'b0, tok_line, ERR_NONE);
          else begin
            emit(K_NUM, 8'h00, 1'b0, 1'b1, tok_line, ERR_NONE);
            open_token(c);
          end
        end
        MODE_STR: begin
          if (c == CH_QUOTE) begin
            emit(K_STR, 8'h00, 1'b0, 1'b1, tok_line, ERR_NONE);
            scan_mode = MODE_IDLE;
          end else emit(K_STR, c, 1'b1, 1'b0, tok_line, ERR_NONE);
        end
        default: open_token(c);
      endcase
      if (scan_mode != MODE_ERR) begin
        if (c == CH_LF) begin
          if (line_no != POS_MAX) line_no++;
          col_no = 1;
        end else if (col_no != POS_MAX) begin
          col_no++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      restart();
      tokens_due.delete();
      tokens_owed = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tokens_due.size() == 0) begin
          $error("result with none due: kind %0d, column %0d", out_data.kind, out_data.column);
          mismatches++;
        end else begin
          want = tokens_due.pop_front();
          tokens_owed--;
          check_field("kind", want.kind, out_data.kind);
          check_field("text_byte", want.text_byte, out_data.text_byte);
          check_field("text_valid", want.text_valid, out_data.text_valid);
          check_field("token_last", want.token_last, out_data.token_last);
          check_field("line", want.line, out_data.line);
          check_field("column", want.column, out_data.column);
          check_field("error", want.error, out_data.error);
        end
      end
      if (in_valid && !in_stall) scan_byte(in_data);
    end
  end

endmodule

>>> tb/source_token_scanner_tb.sv
module source_token_scanner_tb;
  import stsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASE_ITEMS    = 440;

  localparam int SEND_PCT[4]  = '{0, 70, 0, 26};
  localparam int STALL_PCT[4] = '{0, 0, 70, 26};

  localparam string IDENT_HEAD = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
  localparam string IDENT_TAIL = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
  localparam string DIGITS     = "0123456789";
  localparam string NUM_TAIL   = "0123456789.";
  localparam string OPS        = "+-*=()[]{};/";
  localparam string SPACES     = " \t\n\v\f\r";

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  logic hold_req   = 1'b0;
  int   hold_count = 0;
  int   send_pct   = 0;
  int   stall_pct  = 0;
  int   items_sent = 0;
  int   quiet_cycles = 0;
  int   mismatches;
  int   tokens_owed;

  source_token_scanner u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  token_stream_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .tokens_owed(tokens_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      hold_count <= 0;
    end else if (hold_req && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      if (!hold_req) hold_count <= 0;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_from(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  task automatic put_item(input logic [7:0] c, input logic e);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{ch: c, is_end: e};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_item(s[i], 1'b0);
  endtask

  // drop valid and hold until every due result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (tokens_owed == 0);
    @(posedge clk);
  endtask

  task automatic random_stream();
    logic [7:0] src[$];
    logic [7:0] b;
    int         n_tok;
    int         len;
    n_tok = $urandom_range(1, 8);
    repeat (n_tok) begin
      len = $urandom_range(0, 6);
      case ($urandom_range(0, 9))
        0: begin
          src = {src, pick_from(IDENT_HEAD)};
          repeat (len) src = {src, pick_from(IDENT_TAIL)};
        end
        1: begin
          src = {src, pick_from(DIGITS)};
          repeat (len) src = {src, pick_from(NUM_TAIL)};
        end
        2: begin
          src = {src, CH_QUOTE};
          repeat (len) begin
            do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
            src = {src, b};
          end
          if ($urandom_range(9) != 0) src = {src, CH_QUOTE};
        end
        3: begin
          src = {src, CH_SLASH};
          src = {src, CH_SLASH};
          repeat (len) begin
            do b = 8'($urandom_range(255)); while (b == CH_LF);
            src = {src, b};
          end
          if ($urandom_range(9) != 0) src = {src, CH_LF};
        end
        4: begin
          src = {src, CH_SLASH};
          src = {src, CH_STAR};
          repeat (len) begin
            if ($urandom_range(2) == 0) src = {src, CH_STAR};
            else src = {src, 8'($urandom_range(255))};
          end
          if ($urandom_range(9) != 0) begin
            src = {src, CH_STAR};
            src = {src, CH_SLASH};
          end
        end
        5: src = {src, pick_from(OPS)};
        6, 7: repeat (len / 2 + 1) src = {src, pick_from(SPACES)};
        8: src = {src, CH_LF};
        default: begin
          if ($urandom_range(3) == 0) src = {src, 8'($urandom_range(255))};
          else src = {src, pick_from(SPACES)};
        end
      endcase
    end
    foreach (src[i]) put_item(src[i], 1'b0);
    put_item(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    int base;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // block comment with held stars, line comment, divide, every operator,
    // identifier closed by a quote, unterminated string
    put_text("/**x*/");
    put_text("//");
    put_item(8'hFF, 1'b0);
    put_text("\n/+-=()[]{};*_9\"");
    put_item(8'h00, 1'b0);
    put_item(8'h00, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_pct  = SEND_PCT[p];
      stall_pct = STALL_PCT[p];
      base = items_sent;
      while (items_sent - base < PHASE_ITEMS) random_stream();
      drain();
    end

    // hold the output side off while the sender keeps pushing
    send_pct  = 0;
    stall_pct = 0;
    hold_req <= 1'b1;
    put_item(CH_USCORE, 1'b0);
    repeat (60) put_item(pick_from(IDENT_TAIL), 1'b0);
    put_item(8'h00, 1'b1);
    hold_req <= 1'b0;
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
